### hdl/chdg_pkg.sv
// Shared widths, types and the CORDIC arctangent table of the compass heading averager.
package chdg_pkg;

  localparam int unsigned MAG_W       = 18;
  localparam int unsigned OFS_W       = 15;
  localparam int unsigned SUM_W       = 22;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned HDG_W       = 15;
  localparam int unsigned SAMPLES_DEF = 3;

  // CORDIC datapath: 30 fraction bits on top of the sums, room for the gain
  localparam int unsigned STEPS  = 23;
  localparam int unsigned FRAC_W = 30;
  localparam int unsigned DP_W   = 55;
  localparam int unsigned Z_W    = 31;

  localparam logic signed [Z_W-1:0] HALF_TURN   = 31'sd188743680;  // 180 deg, 2^-20 deg units
  localparam int                    HDG_MAX     = 11520;
  localparam int unsigned           ROUND_SH    = 14;
  localparam int                    ROUND_BIAS  = 8192;

  localparam int unsigned FIFO_DEPTH = 2;

  // APB register map
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 1'b1;

  localparam logic signed [OFS_W-1:0] OFFSET_X_RST = 15'sd768;
  localparam logic signed [OFS_W-1:0] OFFSET_Y_RST = -15'sd160;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
  } sums_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // atan(2^-i) in 2^-20 degree units, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      0:       val = 31'sd47185920;
      1:       val = 31'sd27855475;
      2:       val = 31'sd14718068;
      3:       val = 31'sd7471121;
      4:       val = 31'sd3750058;
      5:       val = 31'sd1876857;
      6:       val = 31'sd938658;
      7:       val = 31'sd469357;
      8:       val = 31'sd234682;
      9:       val = 31'sd117342;
      10:      val = 31'sd58671;
      11:      val = 31'sd29335;
      12:      val = 31'sd14668;
      13:      val = 31'sd7334;
      14:      val = 31'sd3667;
      15:      val = 31'sd1833;
      16:      val = 31'sd917;
      17:      val = 31'sd458;
      18:      val = 31'sd229;
      19:      val = 31'sd115;
      20:      val = 31'sd57;
      21:      val = 31'sd29;
      22:      val = 31'sd14;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### hdl/chdg_front.sv
// Front end: hard-iron correction and group accumulation of magnetometer samples.
module chdg_front
  import chdg_pkg::*;
#(
  parameter int unsigned SAMPLES = SAMPLES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [MAG_W-1:0] mag_x_i,
  input  logic signed [MAG_W-1:0] mag_y_i,
  input  logic signed [OFS_W-1:0] offset_x_i,
  input  logic signed [OFS_W-1:0] offset_y_i,
  input  logic                    fifo_full_i,
  output logic                    push_o,
  output sums_t                   sums_o
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES - 1);

  logic                    accept;
  logic                    last;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [SUM_W-1:0] sum_x_q, sum_x_d;
  logic signed [SUM_W-1:0] sum_y_q, sum_y_d;
  logic signed [SUM_W-1:0] cx, cy;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (cnt_q == LAST);

  // sums wrap in SUM_W bits
  assign cx      = SUM_W'(mag_x_i) + SUM_W'(offset_x_i);
  assign cy      = SUM_W'(mag_y_i) + SUM_W'(offset_y_i);
  assign sum_x_d = sum_x_q + cx;
  assign sum_y_d = sum_y_q + cy;
  assign cnt_d   = cnt_q + CNT_W'(1);

  assign push_o       = accept && last;
  assign sums_o.sum_x = sum_x_d;
  assign sums_o.sum_y = sum_y_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (accept) begin
      if (last) begin
        cnt_q   <= '0;
        sum_x_q <= '0;
        sum_y_q <= '0;
      end else begin
        cnt_q   <= cnt_d;
        sum_x_q <= sum_x_d;
        sum_y_q <= sum_y_d;
      end
    end
  end

endmodule

### hdl/chdg_fifo.sv
// Short queue of completed group sums between the front end and the CORDIC.
module chdg_fifo
  import chdg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sums_t      data_i,
  input  logic       pop_i,
  output sums_t      data_o,
  output fifo_stat_t stat_o
);

  localparam int unsigned PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FCNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FCNT_W-1:0] CNT_FULL = FCNT_W'(FIFO_DEPTH);

  sums_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_FULL);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + FCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - FCNT_W'(1);
      end
    end
  end

endmodule

### hdl/chdg_cordic.sv
// Back end: pipelined vectoring CORDIC, rounding, clamp and output register.
module chdg_cordic
  import chdg_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  sums_t                   sums_i,
  output logic                    pop_o,
  output logic signed [HDG_W-1:0] heading_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i
);

  localparam int unsigned EXT_W = DP_W - SUM_W - 1 - FRAC_W;
  localparam int unsigned RZ_W  = Z_W + 1;
  localparam int unsigned H_W   = RZ_W - ROUND_SH;
  localparam logic signed [H_W-1:0]  H_MAX = H_W'(HDG_MAX);
  localparam logic signed [H_W-1:0]  H_MIN = -H_W'(HDG_MAX);
  localparam logic signed [RZ_W-1:0] BIAS  = RZ_W'(ROUND_BIAS);

  logic adv;

  logic signed [DP_W-1:0] u_q  [STEPS+1];
  logic signed [DP_W-1:0] v_q  [STEPS+1];
  logic signed [Z_W-1:0]  z_q  [STEPS+1];
  logic                   zero_q [STEPS+1];
  logic                   vld_q  [STEPS+1];

  logic signed [DP_W-1:0] u_nx [STEPS];
  logic signed [DP_W-1:0] v_nx [STEPS];
  logic signed [Z_W-1:0]  z_nx [STEPS];

  logic signed [SUM_W:0]  u_ext, v_ext, u_pre, v_pre;
  logic                   neg;
  logic signed [DP_W-1:0] u_sc, v_sc;
  logic signed [Z_W-1:0]  z_pre;
  logic                   zero_pre;

  logic signed [RZ_W-1:0]  z_rnd;
  logic signed [H_W-1:0]   h_full;
  logic signed [HDG_W-1:0] heading_d, heading_q;
  logic                    out_valid_q;

  // whole pipeline moves together; a held result stalls it
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = in_valid_i && adv;

  // entry stage: fold the left half plane onto the right, scale up
  assign u_ext    = (SUM_W+1)'(sums_i.sum_y);
  assign v_ext    = (SUM_W+1)'(sums_i.sum_x);
  assign neg      = sums_i.sum_y[SUM_W-1];
  assign u_pre    = neg ? -u_ext : u_ext;
  assign v_pre    = neg ? -v_ext : v_ext;
  assign z_pre    = neg ? (sums_i.sum_x[SUM_W-1] ? -HALF_TURN : HALF_TURN) : '0;
  assign zero_pre = (sums_i.sum_x == '0) && (sums_i.sum_y == '0);
  assign u_sc     = {{EXT_W{u_pre[SUM_W]}}, u_pre, {FRAC_W{1'b0}}};
  assign v_sc     = {{EXT_W{v_pre[SUM_W]}}, v_pre, {FRAC_W{1'b0}}};

  // one micro-rotation per stage, driving v toward zero
  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      if (!v_q[k][DP_W-1]) begin
        u_nx[k] = u_q[k] + (v_q[k] >>> k);
        v_nx[k] = v_q[k] - (u_q[k] >>> k);
        z_nx[k] = z_q[k] + atan_entry(k);
      end else begin
        u_nx[k] = u_q[k] - (v_q[k] >>> k);
        v_nx[k] = v_q[k] + (u_q[k] >>> k);
        z_nx[k] = z_q[k] - atan_entry(k);
      end
    end
  end

  // round to nearest 1/64 degree, ties upward, then clamp; a zero vector gives 0
  assign z_rnd  = RZ_W'(z_q[STEPS]) + BIAS;
  assign h_full = z_rnd[RZ_W-1:ROUND_SH];

  always_comb begin
    if (zero_q[STEPS]) begin
      heading_d = '0;
    end else if (h_full > H_MAX) begin
      heading_d = HDG_W'(H_MAX);
    end else if (h_full < H_MIN) begin
      heading_d = HDG_W'(H_MIN);
    end else begin
      heading_d = HDG_W'(h_full);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_q[0]    <= u_sc;
      v_q[0]    <= v_sc;
      z_q[0]    <= z_pre;
      zero_q[0] <= zero_pre;
      for (int k = 0; k < STEPS; k++) begin
        u_q[k+1]    <= u_nx[k];
        v_q[k+1]    <= v_nx[k];
        z_q[k+1]    <= z_nx[k];
        zero_q[k+1] <= zero_q[k];
      end
      heading_q <= heading_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= STEPS; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int k = 0; k < STEPS; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
      out_valid_q <= vld_q[STEPS];
    end
  end

  assign heading_o   = heading_q;
  assign out_valid_o = out_valid_q;

endmodule

### hdl/compass_heading_averager.sv
// Top level of the compass heading averager: register port, front end, queue and CORDIC.
//
// Takes one X/Y magnetometer sample per clock, adds the hard-iron offsets and
// sums each group of SAMPLES samples; the last sample of a group yields one
// heading, atan2(sum_x, sum_y) in signed 1/64 degree (-11520..11520, 0 for a
// zero vector). Samples are accepted every cycle as long as the two-entry sum
// queue has room. Once its last sample is accepted, the sums of a group pass
// through the queue, the entry stage, the further CORDIC stages and the output
// register to become its heading. The pipelined CORDIC takes one group per
// cycle and stalls as a whole while a heading waits at the output. Offsets sit
// at byte addresses 0 (offset_x) and 4 (offset_y); the user must write them only
// while the block is idle, which the block itself does not enforce.
module compass_heading_averager
  import chdg_pkg::*;
#(
  parameter int unsigned SAMPLES = SAMPLES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [MAG_W-1:0] mag_x_i,
  input  logic signed [MAG_W-1:0] mag_y_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [HDG_W-1:0] heading_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  logic signed [OFS_W-1:0] offset_x_q, offset_y_q;
  logic                    cfg_wr;
  logic [REG_IDX_W-1:0]    reg_idx;

  logic       push, pop;
  sums_t      push_sums, head_sums;
  fifo_stat_t fifo_stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= OFFSET_X_RST;
      offset_y_q <= OFFSET_Y_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OFFSET_X: offset_x_q <= pwdata[OFS_W-1:0];
        REG_OFFSET_Y: offset_y_q <= pwdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OFFSET_X: prdata = PDATA_W'(offset_x_q);
      REG_OFFSET_Y: prdata = PDATA_W'(offset_y_q);
      default:      prdata = '0;
    endcase
  end

  chdg_front #(
    .SAMPLES(SAMPLES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mag_x_i     (mag_x_i),
    .mag_y_i     (mag_y_i),
    .offset_x_i  (offset_x_q),
    .offset_y_i  (offset_y_q),
    .fifo_full_i (fifo_stat.full),
    .push_o      (push),
    .sums_o      (push_sums)
  );

  chdg_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_sums),
    .pop_i  (pop),
    .data_o (head_sums),
    .stat_o (fifo_stat)
  );

  chdg_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!fifo_stat.empty),
    .sums_i      (head_sums),
    .pop_o       (pop),
    .heading_o   (heading_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

`ifndef SYNTHESIS
  // a completed group must never find the queue full
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_stat.full)
    else $error("group sums pushed into a full queue");

  // the CORDIC only takes sums that are there
  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("queue popped while empty");

  // a transfer into the queue leaves it non-empty on the next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !fifo_stat.empty)
    else $error("pushed group sums lost");
`endif

endmodule

### tb/compass_heading_averager_tb.sv
`timescale 1ns / 100ps
// Testbench of the compass heading averager: queued driver, monitor and heading predictor.
module compass_heading_averager_tb;
  import chdg_pkg::*;

  localparam int unsigned GROUP_LEN    = SAMPLES_DEF;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_AT      = 30;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int          TIMEOUT_NS   = 400_000;

  localparam logic signed [MAG_W-1:0] MAG_MAX = {1'b0, {(MAG_W-1){1'b1}}};
  localparam logic signed [MAG_W-1:0] MAG_MIN = {1'b1, {(MAG_W-1){1'b0}}};
  localparam logic signed [OFS_W-1:0] OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};
  localparam logic signed [OFS_W-1:0] OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};
  localparam logic [PADDR_W-1:0] ADDR_OFFSET_X = {REG_OFFSET_X, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_OFFSET_Y = {REG_OFFSET_Y, 2'b00};

  // arctangent of 2^-i, 2^-20 degree units
  localparam longint ATAN_Q20 [STEPS] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
    469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14
  };
  localparam longint PI_Q20 = 188743680;

  typedef struct packed {
    logic signed [MAG_W-1:0] x;
    logic signed [MAG_W-1:0] y;
  } mag_sample_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic signed [MAG_W-1:0] mag_x_i     = '0;
  logic signed [MAG_W-1:0] mag_y_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [HDG_W-1:0] heading_o;
  logic                    psel        = 1'b0;
  logic                    penable     = 1'b0;
  logic                    pwrite      = 1'b0;
  logic [PADDR_W-1:0]      paddr       = '0;
  logic [PDATA_W-1:0]      pwdata      = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  compass_heading_averager #(
    .SAMPLES(GROUP_LEN)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mag_x_i    (mag_x_i),
    .mag_y_i    (mag_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .heading_o  (heading_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // shadow of the offsets and the running group sums
  logic signed [OFS_W-1:0] ofs_x_cfg = OFFSET_X_RST;
  logic signed [OFS_W-1:0] ofs_y_cfg = OFFSET_Y_RST;
  logic signed [SUM_W-1:0] acc_x     = '0;
  logic signed [SUM_W-1:0] acc_y     = '0;
  int unsigned             group_fill = 0;

  mag_sample_t             sample_q[$];
  logic signed [HDG_W-1:0] heading_q[$];
  int unsigned             mismatch_count = 0;
  int unsigned             heading_count  = 0;

  function automatic logic signed [HDG_W-1:0] cordic_heading(longint sx, longint sy);
    longint u, v, z, du, dv, h;
    int i;
    u = sy;
    v = sx;
    z = 0;
    if (u == 0 && v == 0) return '0;
    if (u < 0) begin
      z = (v >= 0) ? PI_Q20 : -PI_Q20;
      u = -u;
      v = -v;
    end
    u = u * 64'sd1073741824;
    v = v * 64'sd1073741824;
    for (i = 0; i < STEPS; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (v >= 0) begin
        u = u + du;
        v = v - dv;
        z = z + ATAN_Q20[i];
      end else begin
        u = u - du;
        v = v + dv;
        z = z - ATAN_Q20[i];
      end
    end
    h = (z + ROUND_BIAS) >>> ROUND_SH;
    if (h > HDG_MAX) h = HDG_MAX;
    if (h < -HDG_MAX) h = -HDG_MAX;
    return h[HDG_W-1:0];
  endfunction

  // add one corrected sample; the last one of a group yields a heading
  task automatic accumulate(logic signed [MAG_W-1:0] x, logic signed [MAG_W-1:0] y);
    acc_x = acc_x + SUM_W'(x) + SUM_W'(ofs_x_cfg);
    acc_y = acc_y + SUM_W'(y) + SUM_W'(ofs_y_cfg);
    if (group_fill + 1 >= GROUP_LEN) begin
      heading_q.push_back(cordic_heading(longint'(acc_x), longint'(acc_y)));
      acc_x      = '0;
      acc_y      = '0;
      group_fill = 0;
    end else begin
      group_fill = group_fill + 1;
    end
  endtask

  // driver: bursts of transfers with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  mag_sample_t drv_next;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) accumulate(mag_x_i, mag_y_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          drv_next = sample_q.pop_front();
          in_valid_i <= 1'b1;
          mag_x_i    <= drv_next.x;
          mag_y_i    <= drv_next.y;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: randomly chosen stall patterns that switch at random, plus one long hold-off
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;
  int unsigned rx_tick    = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
      mode_left   <= 0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left   <= hold_left - 1;
      end else if (!hold_done && heading_count >= HOLD_AT) begin
        out_ready_i <= 1'b0;
        hold_left   <= HOLD_CYCLES;
        hold_done   <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) != 0);
          2: out_ready_i <= (rx_tick % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // monitor
  logic signed [HDG_W-1:0] heading_exp;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      heading_count <= heading_count + 1;
      if (heading_q.size() == 0) begin
        $display("%0t: unexpected heading transfer, actual %0d", $time, heading_o);
        mismatch_count <= mismatch_count + 1;
      end else begin
        heading_exp = heading_q.pop_front();
        if (heading_o !== heading_exp) begin
          $display("%0t: heading mismatch, expected %0d actual %0d",
                   $time, heading_exp, heading_o);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic signed [OFS_W-1:0] value);
    logic [PDATA_W-1:0] data;
    data = $urandom;  // upper bits are don't-care for the 15-bit registers
    data[OFS_W-1:0] = value;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_OFFSET_X) ofs_x_cfg = value;
    else ofs_y_cfg = value;
  endtask

  task automatic set_offsets(logic signed [OFS_W-1:0] ox, logic signed [OFS_W-1:0] oy);
    apb_write(ADDR_OFFSET_X, ox);
    apb_write(ADDR_OFFSET_Y, oy);
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid_i || heading_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_group(logic signed [MAG_W-1:0] x, logic signed [MAG_W-1:0] y);
    repeat (GROUP_LEN) sample_q.push_back('{x: x, y: y});
  endtask

  function automatic logic signed [MAG_W-1:0] pick_mag(logic signed [OFS_W-1:0] ofs);
    int unsigned r;
    logic signed [MAG_W-1:0] m;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 5))
        0: m = MAG_MAX;
        1: m = MAG_MIN;
        2: m = '0;
        3: m = '1;
        4: m = 18'sd78592;
        default: m = -18'sd78592;
      endcase
    end else if (r < 25) begin
      m = MAG_W'($urandom);
    end else if (r < 75) begin
      m = MAG_W'(int'($urandom_range(0, 157184)) - 78592);
    end else begin
      // near the offset, so the corrected sum lands close to or on zero
      m = -MAG_W'(ofs) + MAG_W'(int'($urandom_range(0, 8)) - 4);
    end
    return m;
  endfunction

  task automatic push_random(int unsigned n);
    repeat (n) sample_q.push_back('{x: pick_mag(ofs_x_cfg), y: pick_mag(ofs_y_cfg)});
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset offsets, axis cases and the extremes of the inputs
    push_group(-MAG_W'(ofs_x_cfg), -MAG_W'(ofs_y_cfg));
    push_group(-MAG_W'(ofs_x_cfg), 18'sd4000);
    push_group(-MAG_W'(ofs_x_cfg), -18'sd4000);
    push_group(18'sd4000, -MAG_W'(ofs_y_cfg));
    push_group(-MAG_W'(ofs_x_cfg) - 18'sd4000, -MAG_W'(ofs_y_cfg));
    push_group(MAG_MAX, MAG_MAX);
    push_group(MAG_MIN, MAG_MIN);
    push_group(MAG_MAX, MAG_MIN);
    push_random(230);
    wait_idle();

    set_offsets(OFS_MIN, OFS_MAX);
    push_random(130);
    wait_idle();

    set_offsets(OFS_MAX, OFS_MIN);
    push_random(130);
    wait_idle();

    set_offsets('0, '0);
    push_random(110);
    wait_idle();

    set_offsets(OFS_W'($urandom), OFS_W'($urandom));
    push_random(120);
    wait_idle();

    if (mismatch_count == 0 && heading_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
